>>> sv/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared types and constants for the deframer and its checker.
// ----------------------------------------------------------------------------
package wsdf_pkg;

   // parse position within a frame
   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_KEY,
      PH_PAY
   } phase_type;

   // per-byte result code
   typedef enum logic [2:0] {
      ST_HEADER,
      ST_PAYLOAD,
      ST_FRAG,
      ST_CLOSE,
      ST_LONG,
      ST_HALTED
   } status_type;

   localparam int          CSR_ADDR_W        = 3;
   localparam logic        CSR_IDX_MAX_PAY   = 1'b0;
   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4096;

   localparam logic [3:0]  OPC_CLOSE   = 4'h8;
   localparam logic [6:0]  LEN7_EXT16  = 7'd126;
   localparam logic [6:0]  LEN7_EXT64  = 7'd127;
   localparam logic [3:0]  EXT16_BYTES = 4'd2;
   localparam logic [3:0]  EXT64_BYTES = 4'd8;
   localparam logic [2:0]  KEY_BYTES   = 3'd4;

endpackage

>>> sv/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received byte stream into header and unmasked payload bytes.
// ----------------------------------------------------------------------------
// The block returns exactly one result per byte from a single result register,
// loaded on the transfer; a new byte is taken in every cycle in which that
// register is empty or is being drained, so with rsp_ready held high the
// sustained rate is one stream byte per clock. Each byte is decoded
// by the parse state (header, extended length, mask key, payload) in the same
// cycle it is taken; payload bytes leave XORed with the mask key. A
// fragmented frame, a close frame or a payload longer than max_payload_bytes
// (CSR at address 0) reports an error once, after which every byte reports
// halted until reset.
module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   // stream in
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   // results out
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_status,
   output logic        rsp_frame_last,
   output logic [3:0]  rsp_frame_opcode,
   // configuration
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [wsdf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   // configuration
   logic [31:0] max_pay_ff;
   logic        csr_hit;

   // parse state
   wsdf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  hdr_first_ff, hdr_first_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [63:0] length_ff, length_in;
   logic        mask_present_ff, mask_present_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [2:0]  key_left_ff, key_left_in;
   logic [63:0] pay_left_ff, pay_left_in;
   logic [1:0]  mask_idx_ff, mask_idx_in;
   logic        halted_ff, halted_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   wsdf_pkg::status_type status_ff, status_in;
   logic                 last_ff, last_in;
   logic [3:0]           opcode_ff;

   // shared decode
   logic        req_fire;
   logic [6:0]  len7;
   logic        err_frag, err_close;
   logic [3:0]  ext_left_adv;
   logic [2:0]  key_left_adv;
   logic [63:0] length_adv;
   logic        mask_present_adv;
   logic        hdr_step, hdr_more, too_long, len_zero, pay_end;
   logic [7:0]  key_byte;

   assign req_fire  = req_valid & req_ready;
   assign req_ready = ~reset & (~rsp_valid_ff | rsp_ready);

   // ---- configuration port ----
   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == wsdf_pkg::CSR_IDX_MAX_PAY);
   assign prdata  = csr_hit ? max_pay_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pay_ff <= wsdf_pkg::MAX_PAYLOAD_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         max_pay_ff <= pwdata;
      end
   end

   // ---- header field advance for the current byte ----
   assign len7      = req_in_byte[6:0];
   assign err_frag  = ~hdr_first_ff[7];
   assign err_close = (hdr_first_ff[3:0] == wsdf_pkg::OPC_CLOSE);

   always_comb begin
      ext_left_adv     = ext_left_ff;
      key_left_adv     = key_left_ff;
      length_adv       = length_ff;
      mask_present_adv = mask_present_ff;
      unique case (phase_ff)
         wsdf_pkg::PH_HDR1: begin
            mask_present_adv = req_in_byte[7];
            key_left_adv     = req_in_byte[7] ? wsdf_pkg::KEY_BYTES : 3'd0;
            length_adv       = 64'd0;
            if (len7 == wsdf_pkg::LEN7_EXT16) begin
               ext_left_adv = wsdf_pkg::EXT16_BYTES;
            end else if (len7 == wsdf_pkg::LEN7_EXT64) begin
               ext_left_adv = wsdf_pkg::EXT64_BYTES;
            end else begin
               ext_left_adv = 4'd0;
               length_adv   = {57'd0, len7};
            end
         end
         wsdf_pkg::PH_EXT: begin
            length_adv   = {length_ff[55:0], req_in_byte};
            ext_left_adv = ext_left_ff - 4'd1;
         end
         wsdf_pkg::PH_KEY: begin
            key_left_adv = key_left_ff - 3'd1;
         end
         default: ;
      endcase
   end

   assign hdr_step = ((phase_ff == wsdf_pkg::PH_HDR1) && !err_frag && !err_close)
                   || (phase_ff == wsdf_pkg::PH_EXT) || (phase_ff == wsdf_pkg::PH_KEY);
   assign hdr_more = (ext_left_adv != 4'd0) || (mask_present_adv && (key_left_adv != 3'd0));
   assign too_long = (length_adv[63:32] != 32'd0) || (length_adv[31:0] > max_pay_ff);
   assign len_zero = (length_adv == 64'd0);
   assign pay_end  = (pay_left_ff == 64'd1);

   always_comb begin
      unique case (mask_idx_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
      if (!mask_present_ff) begin
         key_byte = 8'd0;
      end
   end

   // ---- next state ----
   always_comb begin
      phase_in        = phase_ff;
      hdr_first_in    = hdr_first_ff;
      ext_left_in     = ext_left_ff;
      length_in       = length_ff;
      mask_present_in = mask_present_ff;
      mask_key_in     = mask_key_ff;
      key_left_in     = key_left_ff;
      pay_left_in     = pay_left_ff;
      mask_idx_in     = mask_idx_ff;
      halted_in       = halted_ff;
      if (!halted_ff) begin
         if (hdr_step) begin
            ext_left_in     = ext_left_adv;
            key_left_in     = key_left_adv;
            length_in       = length_adv;
            mask_present_in = mask_present_adv;
            if (phase_ff == wsdf_pkg::PH_HDR1) begin
               mask_key_in = 32'd0;
            end else if (phase_ff == wsdf_pkg::PH_KEY) begin
               mask_key_in = {mask_key_ff[23:0], req_in_byte};
            end
            priority if (hdr_more) begin
               phase_in = (ext_left_adv != 4'd0) ? wsdf_pkg::PH_EXT : wsdf_pkg::PH_KEY;
            end else if (too_long) begin
               halted_in = 1'b1;
               phase_in  = wsdf_pkg::PH_HDR0;
            end else if (len_zero) begin
               phase_in = wsdf_pkg::PH_HDR0;
            end else begin
               pay_left_in = length_adv;
               mask_idx_in = 2'd0;
               phase_in    = wsdf_pkg::PH_PAY;
            end
         end else begin
            unique case (phase_ff)
               wsdf_pkg::PH_HDR0: begin
                  hdr_first_in = req_in_byte;
                  phase_in     = wsdf_pkg::PH_HDR1;
               end
               wsdf_pkg::PH_PAY: begin
                  mask_idx_in = mask_idx_ff + 2'd1;
                  pay_left_in = pay_left_ff - 64'd1;
                  if (pay_end) begin
                     phase_in = wsdf_pkg::PH_HDR0;
                  end
               end
               default: begin
                  // second header byte with a fragment or close error
                  halted_in = 1'b1;
                  phase_in  = wsdf_pkg::PH_HDR0;
               end
            endcase
         end
      end
   end

   // ---- result for the current byte ----
   always_comb begin
      out_byte_in = 8'd0;
      status_in   = wsdf_pkg::ST_HEADER;
      last_in     = 1'b0;
      if (halted_ff) begin
         status_in = wsdf_pkg::ST_HALTED;
      end else if (hdr_step) begin
         priority if (hdr_more) begin
            status_in = wsdf_pkg::ST_HEADER;
         end else if (too_long) begin
            status_in = wsdf_pkg::ST_LONG;
         end else begin
            last_in = len_zero;
         end
      end else begin
         unique case (phase_ff)
            wsdf_pkg::PH_HDR0: status_in = wsdf_pkg::ST_HEADER;
            wsdf_pkg::PH_PAY: begin
               status_in   = wsdf_pkg::ST_PAYLOAD;
               out_byte_in = req_in_byte ^ key_byte;
               last_in     = pay_end;
            end
            default: begin
               status_in = err_frag ? wsdf_pkg::ST_FRAG : wsdf_pkg::ST_CLOSE;
            end
         endcase
      end
   end

   assign rsp_valid_in = req_fire | (rsp_valid_ff & ~rsp_ready);

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= wsdf_pkg::PH_HDR0;
         hdr_first_ff    <= 8'd0;
         ext_left_ff     <= 4'd0;
         length_ff       <= 64'd0;
         mask_present_ff <= 1'b0;
         mask_key_ff     <= 32'd0;
         key_left_ff     <= 3'd0;
         pay_left_ff     <= 64'd0;
         mask_idx_ff     <= 2'd0;
         halted_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff        <= phase_in;
            hdr_first_ff    <= hdr_first_in;
            ext_left_ff     <= ext_left_in;
            length_ff       <= length_in;
            mask_present_ff <= mask_present_in;
            mask_key_ff     <= mask_key_in;
            key_left_ff     <= key_left_in;
            pay_left_ff     <= pay_left_in;
            mask_idx_ff     <= mask_idx_in;
            halted_ff       <= halted_in;
         end
      end
   end

   // load the result on transfer; hold while stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_byte_ff <= out_byte_in;
         status_ff   <= status_in;
         last_ff     <= last_in;
         opcode_ff   <= hdr_first_in[3:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_status       = status_ff;
   assign rsp_frame_last   = last_ff;
   assign rsp_frame_opcode = opcode_ff;

endmodule

>>> sv/wsdf_checker.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module wsdf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_status,
   input logic       rsp_frame_last,
   input logic [3:0] rsp_frame_opcode
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_frame_last) && $stable(rsp_frame_opcode))
      else $error("result changed while stalled");

   // data only on payload bytes
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != wsdf_pkg::ST_PAYLOAD) |-> rsp_out_byte == 8'd0)
      else $error("non-zero data on a non-payload result");

   // a frame only ends on a good header or payload byte
   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |->
         (rsp_status == wsdf_pkg::ST_HEADER) || (rsp_status == wsdf_pkg::ST_PAYLOAD))
      else $error("frame end flagged on an error result");

   // once a halted result is taken, a valid result that directly follows it is also halted
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_status == wsdf_pkg::ST_HALTED)
         ##1 rsp_valid |-> rsp_status == wsdf_pkg::ST_HALTED)
      else $error("result left the halted state");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_status       (rsp_status),
   .rsp_frame_last   (rsp_frame_last),
   .rsp_frame_opcode (rsp_frame_opcode)
);
